// File: rtl/pcc_pkg.sv
// Package for the packet checksum check unit: beat types, header layout
// constants and the checksum modulus. No dependencies.
package pcc_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CountW  = 13;
  localparam int unsigned LenW    = 14;
  localparam int unsigned CkW     = 23;
  localparam int unsigned NibbleW = 4;

  // Checksum modulus, 2^23 - 1; note 2^23 is congruent to 1 under it.
  localparam logic [CkW-1:0] CkModulus = {CkW{1'b1}};

  // Word indices within the 16-byte header.
  localparam logic [CountW-1:0] HdrWord0 = CountW'(0);
  localparam logic [CountW-1:0] HdrWord1 = CountW'(1);
  localparam logic [CountW-1:0] HdrWord2 = CountW'(2);
  localparam logic [CountW-1:0] HdrWord3 = CountW'(3);
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Input beat: one packet word.
  typedef struct packed {
    logic [WordW-1:0] word;
    logic             last_word;
  } pcc_in_t;

  // Output beat: the check result for one packet.
  typedef struct packed {
    logic [CkW-1:0] computed_checksum;
    logic [CkW-1:0] stored_checksum;
    logic           checksum_ok;
  } pcc_out_t;

endpackage

// File: rtl/packet_checksum_check_unit.sv
// Packet checksum check unit: header unpacking, running sum and final check.
// Depends on pcc_pkg for the beat types and constants.
//
// Usage:
//   Packet words enter on the input channel (in_valid_i / in_ready_o, payload
//   in_i), one 32-bit big-endian word per beat, last_word set on the final
//   word. The first four words are the header; every header field except the
//   checksum, and the absolute value of each payload word whose byte offset is
//   below the length field, are added into a wrapping 32-bit sum.
//   One result beat per packet leaves on the output channel (out_valid_o /
//   out_ready_i, payload out_o): the sum modulo 2^23 - 1, the stored checksum
//   and a match flag. Words without last_word give no result.
//   Throughput: one word per cycle while the output is not stalled, set by the single accumulate stage.
//   Latency: two register stages. The edge that accepts the last word
//   registers the final sum; the output register then takes that sum folded
//   modulo 2^23 - 1 as soon as the output register is free.
//   Reset clears the word counter, the sum, the header state and both
//   pipeline valid flags; in_ready_o is already high when reset is released.
//   When the receiver stalls, results hold in the output and sum registers;
//   input stops only once both are full.
module packet_checksum_check_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pcc_pkg::pcc_in_t   in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pcc_pkg::pcc_out_t  out_o
);

  import pcc_pkg::*;

  // Accumulation state.
  logic [CountW-1:0]  word_count_q, word_count_d;
  logic [WordW-1:0]   running_sum_q, running_sum_d;
  logic [NibbleW-1:0] carried_nibble_q, carried_nibble_d;
  logic [LenW-1:0]    packet_length_q, packet_length_d;
  logic [CkW-1:0]     header_checksum_q, header_checksum_d;

  // Final sum stage and output stage.
  logic               sum_valid_q;
  logic [WordW-1:0]   final_sum_q;
  logic [CkW-1:0]     final_stored_q;
  logic               out_valid_q;
  pcc_out_t           out_q;

  logic               in_fire;
  logic               sum_ready;
  logic               out_free;
  logic [WordW-1:0]   w;
  logic [WordW-1:0]   abs_word;
  logic [CountW+1:0]  byte_offset;
  logic [CkW:0]       folded;
  logic [CkW-1:0]     reduced;

  // Handshake: each stage takes a new beat when empty or when draining.
  assign out_free   = !out_valid_q || out_ready_i;
  assign sum_ready  = !sum_valid_q || out_free;
  assign in_ready_o = sum_ready;
  assign in_fire    = in_valid_i && in_ready_o;

  assign w           = in_i.word;
  assign abs_word    = w[WordW-1] ? (~w + WordW'(1)) : w;
  assign byte_offset = {word_count_q, 2'b00};

  // Header unpacking and payload accumulation for one word.
  always_comb begin
    running_sum_d     = running_sum_q;
    carried_nibble_d  = carried_nibble_q;
    packet_length_d   = packet_length_q;
    header_checksum_d = header_checksum_q;
    case (word_count_q)
      HdrWord0: begin
        running_sum_d    = running_sum_q + {4'b0, w[31:4]};
        carried_nibble_d = w[3:0];
      end
      HdrWord1: begin
        running_sum_d    = running_sum_q + {4'b0, carried_nibble_q, w[31:8]}
                           + {28'b0, w[7:4]} + {28'b0, w[3:0]};
        carried_nibble_d = '0;
      end
      HdrWord2: begin
        packet_length_d  = w[17:4];
        running_sum_d    = running_sum_q + {18'b0, w[31:18]} + {18'b0, w[17:4]};
        carried_nibble_d = w[3:0];
      end
      HdrWord3: begin
        header_checksum_d = w[30:8];
        running_sum_d     = running_sum_q + {27'b0, carried_nibble_q, w[31]}
                            + {30'b0, w[7:6]} + {26'b0, w[5:0]};
        carried_nibble_d  = '0;
      end
      default: begin
        if (byte_offset < {1'b0, packet_length_q}) begin
          running_sum_d = running_sum_q + abs_word;
        end
      end
    endcase
    if (word_count_q != CountMax) begin
      word_count_d = word_count_q + CountW'(1);
    end else begin
      word_count_d = word_count_q;
    end
  end

  // Accumulation state, cleared after every last word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q      <= '0;
      running_sum_q     <= '0;
      carried_nibble_q  <= '0;
      packet_length_q   <= '0;
      header_checksum_q <= '0;
    end else if (in_fire) begin
      if (in_i.last_word) begin
        word_count_q      <= '0;
        running_sum_q     <= '0;
        carried_nibble_q  <= '0;
        packet_length_q   <= '0;
        header_checksum_q <= '0;
      end else begin
        word_count_q      <= word_count_d;
        running_sum_q     <= running_sum_d;
        carried_nibble_q  <= carried_nibble_d;
        packet_length_q   <= packet_length_d;
        header_checksum_q <= header_checksum_d;
      end
    end
  end

  // Final sum register, loaded by the last word of a packet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (sum_ready) begin
      sum_valid_q <= in_fire && in_i.last_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_ready && in_fire && in_i.last_word) begin
      final_sum_q    <= running_sum_d;
      final_stored_q <= header_checksum_d;
    end
  end

  // Fold modulo 2^23 - 1: the top nine bits weigh 1, so add them to the low
  // part; the total stays below twice the modulus, so one subtract finishes.
  assign folded  = {1'b0, final_sum_q[CkW-1:0]} + {{(2*CkW-WordW+1){1'b0}},
                   final_sum_q[WordW-1:CkW]};
  assign reduced = (folded >= {1'b0, CkModulus}) ? CkW'(folded - {1'b0, CkModulus})
                                                 : folded[CkW-1:0];

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= sum_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && sum_valid_q) begin
      out_q.computed_checksum <= reduced;
      out_q.stored_checksum   <= final_stored_q;
      out_q.checksum_ok       <= (reduced == final_stored_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
